// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the degree tracker rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define UGDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define UGDT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/ugdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ugdt_pkg
// shared types and constants of the graph degree tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ugdt_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;

  localparam int unsigned NODE_W    = 6;  // node field width
  localparam int unsigned DEG_W     = 6;  // degree storage and field width
  localparam int unsigned NC_CFG_W  = 7;  // node_count register width
  localparam int unsigned ISO_OUT_W = 7;  // isolated count field width
  localparam int unsigned STATUS_W  = 2;

  localparam logic [NC_CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic [STATUS_W-1:0] STATUS_ADDED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPD_V,
    ST_SCAN,
    ST_DONE
  } ugdt_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, read row and degree of from node
    logic check;   // classify request
    logic edge_u;  // write row and degree of from node
    logic edge_v;  // write row and degree of to node
    logic scan;    // degree summary sweep
  } ugdt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic dup;
    logic scan_done;
  } ugdt_sts_t;

endpackage

`default_nettype wire

// ===== design/undirected_graph_degree_tracker_top.sv =====
// ----------------------------------------------------------------------------
// undirected_graph_degree_tracker_top
// edge insert into an undirected adjacency matrix with a degree summary
//
//   channel   handshake             payload
//   request   start / busy          from_node_i, to_node_i
//   result    done_o (one cycle)    status_o, is_regular_o, max_degree_node_o,
//                                   max_degree_o, isolated_count_o
//   config    cfg_we_i              cfg_wdata_i (node_count)
//
// a beat is taken when start is high and busy is low; one result beat follows
// busy covers the request check, the second row update for an added edge only,
// and the degree sweep over the n active nodes, n being the min of node_count
// and MAX_NODES; the sweep makes one degree ram read per node
// reset clears node_count to 64 and the row valid bits, so the graph is empty
// the result beat cannot be stalled; done_o is high for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module undirected_graph_degree_tracker_top #(
  parameter int unsigned MAX_NODES = ugdt_pkg::MAX_NODES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ugdt_pkg::NODE_W-1:0]    from_node_i,
  input  wire logic [ugdt_pkg::NODE_W-1:0]    to_node_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ugdt_pkg::NC_CFG_W-1:0]  cfg_wdata_i,
  output logic                                done_o,
  output logic      [ugdt_pkg::STATUS_W-1:0]  status_o,
  output logic                                is_regular_o,
  output logic      [ugdt_pkg::NODE_W-1:0]    max_degree_node_o,
  output logic      [ugdt_pkg::DEG_W-1:0]     max_degree_o,
  output logic      [ugdt_pkg::ISO_OUT_W-1:0] isolated_count_o
);

  import ugdt_pkg::*;

  ugdt_cmd_t cmd;  // sequencer commands
  ugdt_sts_t sts;  // check and sweep status

  // sequencer: idle, check, second row update, sweep, result
  ugdt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // storage, request check and summary registers
  ugdt_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .from_node_i       (from_node_i),
    .to_node_i         (to_node_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .status_o          (status_o),
    .is_regular_o      (is_regular_o),
    .max_degree_node_o (max_degree_node_o),
    .max_degree_o      (max_degree_o),
    .isolated_count_o  (isolated_count_o)
  );

  // an accepted request keeps the block busy in the next cycle
  `UGDT_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept without busy")
  // a result beat returns the block to idle
  `UGDT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |=> !busy, "busy after result beat")
  // no result while idle
  `UGDT_ASSERT_NEVER(a_done_idle_state, clk_i, rst_ni, done_o && !busy, "result while idle")
  // a zero maximum degree reports node zero
  `UGDT_ASSERT(a_zero_max, clk_i, rst_ni,
    (done_o && (max_degree_o == '0)) |-> (max_degree_node_o == '0), "max node not zero")
  // status is always one of the defined codes
  `UGDT_ASSERT_NEVER(a_status_code, clk_i, rst_ni,
    done_o && (status_o != STATUS_ADDED) && (status_o != STATUS_REJECT) &&
    (status_o != STATUS_DUP), "bad status code")

endmodule

`default_nettype wire

// ===== design/ugdt_ram.sv =====
// ----------------------------------------------------------------------------
// ugdt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ugdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/ugdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ugdt_ctrl
// sequencer for edge insert and degree sweep
// ----------------------------------------------------------------------------
`default_nettype none

module ugdt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_o,
  input  wire ugdt_pkg::ugdt_sts_t sts_i,
  output ugdt_pkg::ugdt_cmd_t     cmd_o
);

  import ugdt_pkg::*;

  ugdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.bad || sts_i.dup) state_d = ST_SCAN;
        else                        state_d = ST_UPD_V;
      end
      ST_UPD_V: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.edge_u = !sts_i.bad && !sts_i.dup;
      end
      ST_UPD_V: cmd_o.edge_v = 1'b1;
      ST_SCAN:  cmd_o.scan   = 1'b1;
      ST_DONE:  done_o       = 1'b1;
      default:  busy         = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ugdt_dp.sv =====
// ----------------------------------------------------------------------------
// ugdt_dp
// adjacency and degree storage, request check and degree summary
// ----------------------------------------------------------------------------
`default_nettype none

module ugdt_dp #(
  parameter int unsigned MAX_NODES = ugdt_pkg::MAX_NODES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ugdt_pkg::ugdt_cmd_t            cmd_i,
  output ugdt_pkg::ugdt_sts_t                 sts_o,
  input  wire logic [ugdt_pkg::NODE_W-1:0]    from_node_i,
  input  wire logic [ugdt_pkg::NODE_W-1:0]    to_node_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ugdt_pkg::NC_CFG_W-1:0]  cfg_wdata_i,
  output logic      [ugdt_pkg::STATUS_W-1:0]  status_o,
  output logic                                is_regular_o,
  output logic      [ugdt_pkg::NODE_W-1:0]    max_degree_node_o,
  output logic      [ugdt_pkg::DEG_W-1:0]     max_degree_o,
  output logic      [ugdt_pkg::ISO_OUT_W-1:0] isolated_count_o
);

  import ugdt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned CMP_W = (CNT_W > NC_CFG_W) ? CNT_W : NC_CFG_W;

  logic [NC_CFG_W-1:0] node_count_q;
  logic [CNT_W-1:0]    active_n;
  logic                bad_d;

  logic [IDX_W-1:0]    u_q, v_q;
  logic [CNT_W-1:0]    n_q;
  logic                bad_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                dv_q;
  logic [IDX_W-1:0]    sidx_q;
  logic [MAX_NODES-1:0] vld_q;
  logic                rd_vld_q;

  logic [DEG_W-1:0]    ref_q, best_deg_q;
  logic [IDX_W-1:0]    best_node_q;
  logic                regular_q;
  logic [CNT_W-1:0]    iso_q;
  logic [STATUS_W-1:0] status_q;

  logic [IDX_W-1:0]     raddr, waddr, wcol;
  logic                 we, scan_rd;
  logic [MAX_NODES-1:0] adj_rdata, adj_row, adj_wdata;
  logic [DEG_W-1:0]     deg_rdata, deg_rd, deg_wdata;
  logic                 dup;

  // active node count saturates at the array size
  always_comb begin
    if (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) active_n = CNT_W'(MAX_NODES);
    else                                          active_n = CNT_W'(node_count_q);
  end

  assign bad_d = (CMP_W'(from_node_i) >= CMP_W'(active_n)) ||
                 (CMP_W'(to_node_i) >= CMP_W'(active_n)) ||
                 (from_node_i == to_node_i);

  // shared read address for both memories
  always_comb begin
    if (cmd_i.load)       raddr = IDX_W'(from_node_i);
    else if (cmd_i.check) raddr = v_q;
    else if (cmd_i.scan)  raddr = cnt_q[IDX_W-1:0];
    else                  raddr = u_q;
  end

  // rows never written read as zero
  assign adj_row = adj_rdata & {MAX_NODES{rd_vld_q}};
  assign deg_rd  = rd_vld_q ? deg_rdata : '0;
  assign dup     = adj_row[v_q];

  assign we        = cmd_i.edge_u || cmd_i.edge_v;
  assign waddr     = cmd_i.edge_v ? v_q : u_q;
  assign wcol      = cmd_i.edge_v ? u_q : v_q;
  assign adj_wdata = adj_row | ({{(MAX_NODES-1){1'b0}}, 1'b1} << wcol);
  assign deg_wdata = deg_rd + DEG_W'(1);

  assign scan_rd = cmd_i.scan && (cnt_q < n_q);

  assign sts_o.bad       = bad_q;
  assign sts_o.dup       = dup;
  assign sts_o.scan_done = (cnt_q == n_q) && !dv_q;

  ugdt_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (adj_wdata),
    .raddr_i (raddr),
    .rdata_o (adj_rdata)
  );

  ugdt_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_NODES)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (deg_wdata),
    .raddr_i (raddr),
    .rdata_o (deg_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      vld_q        <= '0;
      rd_vld_q     <= 1'b0;
      bad_q        <= 1'b0;
      cnt_q        <= '0;
      dv_q         <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (we) vld_q[waddr] <= 1'b1;
      rd_vld_q <= vld_q[raddr];
      if (cmd_i.load) begin
        bad_q <= bad_d;
        cnt_q <= '0;
        dv_q  <= 1'b0;
      end else begin
        dv_q <= scan_rd;
        if (scan_rd) cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // payload and summary accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q         <= IDX_W'(from_node_i);
      v_q         <= IDX_W'(to_node_i);
      n_q         <= active_n;
      ref_q       <= '0;
      best_deg_q  <= '0;
      best_node_q <= '0;
      regular_q   <= 1'b1;
      iso_q       <= '0;
    end else begin
      if (scan_rd) sidx_q <= cnt_q[IDX_W-1:0];
      if (dv_q) begin
        if (sidx_q == '0) ref_q <= deg_rd;
        else if (deg_rd != ref_q) regular_q <= 1'b0;
        if (deg_rd > best_deg_q) begin
          best_deg_q  <= deg_rd;
          best_node_q <= sidx_q;
        end
        if (deg_rd == '0) iso_q <= iso_q + CNT_W'(1);
      end
    end
    if (cmd_i.check) begin
      if (bad_q)    status_q <= STATUS_REJECT;
      else if (dup) status_q <= STATUS_DUP;
      else          status_q <= STATUS_ADDED;
    end
  end

  assign status_o          = status_q;
  assign is_regular_o      = regular_q;
  assign max_degree_node_o = NODE_W'(best_node_q);
  assign max_degree_o      = best_deg_q;
  assign isolated_count_o  = ISO_OUT_W'(iso_q);

endmodule

`default_nettype wire
